@@ rtl/assert_macros.svh @@
// Assertion helpers
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
`define ASSERT_NORST(label, clk, prop, msg) \
   label: assert property (@(posedge clk) prop) else $error(msg);
`else
`define ASSERT_CLK(label, clk, rst, prop, msg)
`define ASSERT_NORST(label, clk, prop, msg)
`endif
`endif

@@ rtl/rmea_pkg.sv @@
package rmea_pkg;
   localparam int CordicStages = 16;
   localparam int AccW = 28;
   localparam int VecW = 34;
   localparam int SqrtSteps = 17;
   localparam logic signed [AccW-1:0] PiQ24 = 28'sd52707179;
   localparam logic signed [17:0] AngleLimit = 18'sd25736;

   typedef struct packed {
      logic signed [VecW-1:0] x;
      logic signed [VecW-1:0] y;
      logic signed [AccW-1:0] acc;
      logic                   zero;
   } cordic_type;

   typedef struct packed {
      logic [31:0] rem;
      logic [16:0] root;
      logic signed [15:0] r00, r10, r20, r21, r22, r11, r12;
   } sqrt_type;

   function automatic logic signed [AccW-1:0] atan_entry(input int i);
      logic signed [AccW-1:0] t [0:23];
      t = '{28'sd13176795, 28'sd7778716, 28'sd4110060, 28'sd2086331, 28'sd1047214,
            28'sd524117, 28'sd262123, 28'sd131069, 28'sd65536, 28'sd32768, 28'sd16384,
            28'sd8192, 28'sd4096, 28'sd2048, 28'sd1024, 28'sd512, 28'sd256, 28'sd128,
            28'sd64, 28'sd32, 28'sd16, 28'sd8, 28'sd4, 28'sd2};
      return t[i];
   endfunction
endpackage

@@ rtl/rmea_sqrt_cell.sv @@
module rmea_sqrt_cell import rmea_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] step,
   input  sqrt_type   d,
   output sqrt_type   q
);
   sqrt_type q_in, q_ff;
   logic [5:0] sh;
   logic [33:0] trial;
   logic [33:0] part;
   always_comb begin
      sh = 6'(2 * (SqrtSteps - 1 - int'(step)));
      q_in = d;
      part = {2'b00, d.rem} >> sh;
      trial = {15'd0, d.root, 2'b01};
      if (part >= trial) begin
         q_in.rem = d.rem - 32'(trial << sh);
         q_in.root = {d.root[15:0], 1'b1};
      end else begin
         q_in.root = {d.root[15:0], 1'b0};
      end
   end
   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end
   assign q = q_ff;
endmodule

@@ rtl/rmea_cordic_cell.sv @@
module rmea_cordic_cell import rmea_pkg::*; (
   input  logic       clock,
   input  logic       en,
   input  logic [4:0] step,
   input  cordic_type d,
   output cordic_type q
);
   cordic_type q_in, q_ff;
   always_comb begin
      q_in = d;
      if (d.y >= 0) begin
         q_in.x = d.x + (d.y >>> step);
         q_in.y = d.y - (d.x >>> step);
         q_in.acc = d.acc + atan_entry(int'(step));
      end else begin
         q_in.x = d.x - (d.y >>> step);
         q_in.y = d.y + (d.x >>> step);
         q_in.acc = d.acc - atan_entry(int'(step));
      end
   end
   always_ff @(posedge clock) begin
      if (en) q_ff <= q_in;
   end
   assign q = q_ff;
endmodule

@@ rtl/rmea_cordic_chain.sv @@
module rmea_cordic_chain import rmea_pkg::*; (
   input  logic               clock,
   input  logic               en,
   input  logic signed [17:0] y_i,
   input  logic signed [17:0] x_i,
   output logic signed [15:0] angle
);
   cordic_type stage [0:CordicStages];
   cordic_type head;
   logic signed [AccW-1:0] rnd;
   logic signed [AccW-12:0] shr;
   always_comb begin
      head.zero = (x_i == 0) && (y_i == 0);
      head.x = VecW'(x_i) <<< 14;
      head.y = VecW'(y_i) <<< 14;
      head.acc = '0;
      if (x_i < 0) begin
         head.acc = (y_i >= 0) ? PiQ24 : -PiQ24;
         head.x = -head.x;
         head.y = -head.y;
      end
   end
   assign stage[0] = head;
   for (genvar g = 0; g < CordicStages; g++) begin : g_cell
      rmea_cordic_cell u_cell (.clock(clock), .en(en), .step(5'(g)), .d(stage[g]),
                               .q(stage[g+1]));
   end
   always_comb begin
      rnd = stage[CordicStages].acc + AccW'(1024);
      shr = rnd[AccW-1:11];
      if (stage[CordicStages].zero) angle = '0;
      else if (shr > AngleLimit) angle = 16'(AngleLimit);
      else if (shr < -AngleLimit) angle = 16'(-AngleLimit);
      else angle = shr[15:0];
   end
endmodule

@@ rtl/rotation_matrix_to_euler_angles_unit.sv @@
// ZYX Euler angles from a rotation matrix.
// req_tdata carries seven signed Q1.15 elements; rsp_tdata three angles in
// radians with 13 fraction bits, rsp_tuser the singular flag.
// csr_ sets the 15-bit singular threshold (reset 1), written while idle.
// The pipeline is a chain of cells: 17 square-root cells compute sy, then
// three 16-cell CORDIC chains run atan2 for x, y and z in parallel.
// One item per cycle sustained while the receiver keeps taking results.
// The whole chain advances only when the output register is free or being
// taken, so a stalled receiver holds every stage; req_tready follows that.
// Reset clears the valid bits of all stages; the threshold returns to 1.
`include "assert_macros.svh"
module rotation_matrix_to_euler_angles_unit import rmea_pkg::*; (
   input  logic         clock,
   input  logic         reset,
   input  logic         req_tvalid,
   output logic         req_tready,
   input  logic [111:0] req_tdata,  // r00, r10, r20, r21, r22, r11, r12
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   output logic [47:0]  rsp_tdata,  // angle_x, angle_y, angle_z
   output logic         rsp_tuser,  // singular
   input  logic         csr_valid,
   output logic         csr_ready,
   input  logic [14:0]  csr_data
);
   localparam int Depth = SqrtSteps + CordicStages;
   logic [14:0] thr_ff;
   logic [Depth-1:0] vld_ff, vld_in;
   logic en;
   sqrt_type sq [0:SqrtSteps];
   logic sing;
   logic [CordicStages-1:0] sing_ff;
   logic signed [15:0] ax, ay, az;
   logic signed [17:0] xx, xy;

   assign en = !rsp_tvalid || rsp_tready;
   assign req_tready = en;
   assign csr_ready = 1'b1;
   assign vld_in = {vld_ff[Depth-2:0], req_tvalid};
   always_ff @(posedge clock) begin
      if (reset) begin
         vld_ff <= '0;
         thr_ff <= 15'd1;
      end else begin
         if (en) vld_ff <= vld_in;
         if (csr_valid) thr_ff <= csr_data;
      end
   end
   assign rsp_tvalid = vld_ff[Depth-1];

   always_comb begin
      sq[0].r00 = req_tdata[15:0];
      sq[0].r10 = req_tdata[31:16];
      sq[0].r20 = req_tdata[47:32];
      sq[0].r21 = req_tdata[63:48];
      sq[0].r22 = req_tdata[79:64];
      sq[0].r11 = req_tdata[95:80];
      sq[0].r12 = req_tdata[111:96];
      sq[0].root = '0;
      sq[0].rem = 32'(sq[0].r00 * sq[0].r00) + 32'(sq[0].r10 * sq[0].r10);
   end
   for (genvar g = 0; g < SqrtSteps; g++) begin : g_sq
      rmea_sqrt_cell u_sq (.clock(clock), .en(en), .step(5'(g)), .d(sq[g]), .q(sq[g+1]));
   end

   assign sing = sq[SqrtSteps].root < {2'b00, thr_ff};
   assign xy = sing ? -18'(sq[SqrtSteps].r12) : 18'(sq[SqrtSteps].r21);
   assign xx = sing ? 18'(sq[SqrtSteps].r11) : 18'(sq[SqrtSteps].r22);

   rmea_cordic_chain u_x (.clock(clock), .en(en), .y_i(xy), .x_i(xx), .angle(ax));
   rmea_cordic_chain u_y (.clock(clock), .en(en), .y_i(-18'(sq[SqrtSteps].r20)),
                          .x_i({1'b0, sq[SqrtSteps].root}), .angle(ay));
   rmea_cordic_chain u_z (.clock(clock), .en(en), .y_i(18'(sq[SqrtSteps].r10)),
                          .x_i(18'(sq[SqrtSteps].r00)), .angle(az));

   always_ff @(posedge clock) begin
      if (en) sing_ff <= {sing_ff[CordicStages-2:0], sing};
   end
   assign rsp_tuser = sing_ff[CordicStages-1];
   assign rsp_tdata = {(rsp_tuser ? 16'd0 : az), ay, ax};

   `ASSERT_CLK(a_hold, clock, reset, rsp_tvalid && !rsp_tready |=> rsp_tvalid, "lost item")
   `ASSERT_CLK(a_ready, clock, reset, req_tready == (!rsp_tvalid || rsp_tready), "ready")
   `ASSERT_CLK(a_zsing, clock, reset, rsp_tvalid && rsp_tuser |-> rsp_tdata[47:32] == 16'd0,
               "z not zero")
endmodule

@@ test/rotation_matrix_to_euler_angles_unit_tb.sv @@
module rotation_matrix_to_euler_angles_unit_tb import rmea_pkg::*; ();

   localparam int NUM_RANDOM = 550;
   localparam int LATENCY = 33;
   localparam int STAGES = 16;
   localparam longint PI_Q24 = 52707179;
   localparam longint ANGLE_MAX = 25736;

   typedef struct packed {
      logic signed [15:0] r12, r11, r22, r21, r20, r10, r00;
   } matrix_type;

   typedef struct packed {
      logic signed [15:0] ax, ay, az;
      logic               sing;
   } euler_type;

   typedef struct {
      matrix_type m;
      logic       known;
      euler_type  e;
   } vector_type;

   logic         clock;
   logic         reset;
   logic         req_tvalid;
   logic         req_tready;
   logic [111:0] req_tdata;
   logic         rsp_tvalid;
   logic         rsp_tready;
   logic [47:0]  rsp_tdata;
   logic         rsp_tuser;
   logic         csr_valid;
   logic         csr_ready;
   logic [14:0]  csr_data;

   logic [14:0] threshold;
   euler_type   angles_due[$];
   int          errors;

   rotation_matrix_to_euler_angles_unit dut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready), .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready), .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser),
      .csr_valid(csr_valid), .csr_ready(csr_ready), .csr_data(csr_data)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic longint floor_shr(longint v, int s);
      return v >>> s;
   endfunction

   function automatic longint vector_angle(longint y, longint x);
      longint acc, cx, cy, dx, dy;
      acc = 0;
      if (x == 0 && y == 0) return 0;
      cx = x * 16384;
      cy = y * 16384;
      if (cx < 0) begin
         acc = (cy >= 0) ? PI_Q24 : -PI_Q24;
         cx = -cx;
         cy = -cy;
      end
      for (int i = 0; i < STAGES && i < 24; i++) begin
         dx = floor_shr(cy, i);
         dy = floor_shr(cx, i);
         if (cy >= 0) begin
            cx += dx;
            cy -= dy;
            acc += longint'(atan_entry(i));
         end else begin
            cx -= dx;
            cy += dy;
            acc -= longint'(atan_entry(i));
         end
      end
      acc = floor_shr(acc + 1024, 11);
      if (acc > ANGLE_MAX) acc = ANGLE_MAX;
      if (acc < -ANGLE_MAX) acc = -ANGLE_MAX;
      return acc;
   endfunction

   function automatic euler_type euler_from_matrix(matrix_type m);
      longint a, b, n, lo, hi, mid, sy;
      euler_type e;
      a = m.r00;
      b = m.r10;
      n = a * a + b * b;
      lo = 0;
      hi = 65536;
      while (hi - lo > 1) begin
         mid = (lo + hi) / 2;
         if (mid * mid <= n) lo = mid;
         else hi = mid;
      end
      sy = lo;
      e.sing = sy < longint'(threshold);
      e.ay = 16'(vector_angle(-longint'(m.r20), sy));
      if (!e.sing) begin
         e.ax = 16'(vector_angle(m.r21, m.r22));
         e.az = 16'(vector_angle(m.r10, m.r00));
      end else begin
         e.ax = 16'(vector_angle(-longint'(m.r12), m.r11));
         e.az = '0;
      end
      return e;
   endfunction

   function automatic matrix_type rand_matrix(int kind);
      matrix_type m;
      m = matrix_type'(112'({$urandom, $urandom, $urandom, $urandom}));
      if (kind == 1) begin
         m.r00 = 16'($signed($urandom_range(0, 8)) - 4);
         m.r10 = 16'($signed($urandom_range(0, 8)) - 4);
      end else if (kind == 2) begin
         m.r22 = $urandom_range(0, 1) ? 16'sh8000 : 16'sd0;
         m.r21 = '0;
         m.r12 = $urandom_range(0, 1) ? 16'sd0 : m.r12;
      end
      return m;
   endfunction

   task automatic write_threshold(logic [14:0] value);
      @(negedge clock);
      csr_valid <= 1'b1;
      csr_data <= value;
      do @(posedge clock); while (!csr_ready);
      threshold = value;
      @(negedge clock);
      csr_valid <= 1'b0;
   endtask

   task automatic drain();
      @(negedge clock);
      req_tvalid <= 1'b0;
      while (angles_due.size() != 0) @(posedge clock);
      repeat (LATENCY + 4) @(posedge clock);
   endtask

   task automatic send_matrix(matrix_type m, logic known, euler_type given);
      euler_type e;
      int gap;
      gap = $urandom_range(0, 11);
      @(negedge clock);
      if (gap != 0) begin
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= m;
      e = euler_from_matrix(m);
      if (known && e !== given) begin
         $display("%0t predictor row check: expected %h got %h", $time, given, e);
         errors++;
      end
      do @(posedge clock); while (!req_tready);
      angles_due.insert(angles_due.size(), e);
   endtask

   always @(posedge clock) begin
      euler_type got, want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got = {rsp_tdata[15:0], rsp_tdata[31:16], rsp_tdata[47:32], rsp_tuser};
         if (angles_due.size() == 0) begin
            $display("%0t unexpected item: got %h", $time, got);
            errors++;
         end else begin
            want = angles_due.pop_front();
            if (got !== want) begin
               $display("%0t mismatch x/y/z/sing: expected %h got %h", $time, want, got);
               errors++;
            end
         end
      end
   end

   initial begin
      int gap;
      rsp_tready = 1'b0;
      @(negedge clock);
      while (1) begin
         gap = $urandom_range(0, 11);
         if (gap != 0) begin
            rsp_tready <= 1'b0;
            repeat (gap) @(negedge clock);
         end
         rsp_tready <= 1'b1;
         do @(posedge clock); while (!(rsp_tvalid && rsp_tready));
         @(negedge clock);
      end
   end

   initial begin
      #40000000;
      $display("Simulation FAILED");
      $finish;
   end

   initial begin
      vector_type rows[$];
      matrix_type m;
      euler_type none;
      none = '0;
      errors = 0;
      threshold = 15'd1;
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tdata = '0;
      csr_valid = 1'b0;
      csr_data = '0;
      repeat (7) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // identity, zero matrix, extremes, gimbal lock
      rows.insert(rows.size(), '{matrix_type'({16'sd0, 16'sd32767, 16'sd32767, 16'sd0,
                                               16'sd0, 16'sd0, 16'sd32767}), 1'b1,
                                 euler_type'({16'sd0, 16'sd0, 16'sd0, 1'b0})});
      rows.insert(rows.size(), '{matrix_type'(112'd0), 1'b1,
                                 euler_type'({16'sd0, 16'sd0, 16'sd0, 1'b1})});
      rows.insert(rows.size(), '{matrix_type'({7{16'sh8000}}), 1'b0, none});
      rows.insert(rows.size(), '{matrix_type'({7{16'sh7fff}}), 1'b0, none});
      rows.insert(rows.size(), '{matrix_type'({16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd0,
                                               16'sd0, 16'sh8000}), 1'b0, none});
      rows.insert(rows.size(), '{matrix_type'({16'sd0, 16'sd0, 16'sh8000, 16'sd0, 16'sd100,
                                               16'sd0, 16'sd0}), 1'b0, none});
      rows.insert(rows.size(), '{matrix_type'({16'sd5, 16'sh8000, 16'sd0, 16'sd0, 16'sd32767,
                                               16'sd0, 16'sd0}), 1'b0, none});
      rows.insert(rows.size(), '{matrix_type'({16'sd0, 16'sd0, 16'sd0, 16'sh8000, 16'sd0,
                                               16'sd1, 16'sd0}), 1'b0, none});
      foreach (rows[i]) send_matrix(rows[i].m, rows[i].known, rows[i].e);

      for (int phase = 0; phase < 5; phase++) begin
         drain();
         case (phase)
            0: write_threshold(15'd0);
            1: write_threshold(15'h7fff);
            2: write_threshold(15'd3);
            3: write_threshold(15'($urandom));
            default: write_threshold(15'd1);
         endcase
         for (int i = 0; i < NUM_RANDOM / 5; i++) begin
            m = rand_matrix($urandom_range(0, 2));
            send_matrix(m, 1'b0, none);
         end
      end
      drain();
      if (errors == 0) begin
         $display("Simulation PASSED");
      end else begin
         $display("Simulation FAILED");
      end
      $finish;
   end
endmodule
